FILE: src/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Depends on a signal named clk and an active-high reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sspq_pkg.sv
// Shared types, codes and defaults for the stable sorted priority queue.
// No dependencies; the interfaces, the queue top and the cell import it.
package sspq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int PRIO_WIDTH_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int PRIO_IN_W      = 16;
  localparam int STATUS_W       = 2;
  localparam int OCC_W          = 5;

  // Command codes carried on the request channel
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell of the chain does at each clock edge
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

FILE: src/sspq_if.sv
// Valid/ready channel interfaces for the queue's request and response.
// Depends on sspq_pkg for the field widths.
interface sspq_req_if import sspq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [DATA_W-1:0]    data_in;
  logic [PRIO_IN_W-1:0] prio_in;

  modport source (output valid, cmd, data_in, prio_in, input ready);
  modport sink   (input valid, cmd, data_in, prio_in, output ready);
endinterface

interface sspq_rsp_if import sspq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

FILE: src/stable_sorted_priority_queue.sv
// Stable sorted priority queue: a chain of CAPACITY cells kept in ascending
// priority order, one request transaction per clock cycle. Each accepted
// transaction yields one response transaction in the next cycle, held in a
// one-deep output register; a new request is taken in the same cycle that the
// previous response leaves, so the sustained rate is one transaction per cycle
// as long as the response side keeps ready high. That rate is set by the
// cells: on an insert every cell compares its priority with the new one in
// parallel and either holds, takes the new entry or takes its left neighbor;
// on a remove every cell takes its right neighbor and the head leaves. Equal
// priorities leave in arrival order. Status is ok, empty (remove from an empty
// queue, handle reads zero) or full (insert dropped, state unchanged);
// occupancy is the count after the transaction. No clearing pass after reset.
// Depends on sspq_pkg, sspq_if, sspq_cell and assert_macros.svh.
`include "assert_macros.svh"

module stable_sorted_priority_queue import sspq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sspq_req_if.sink    req,
  sspq_rsp_if.source  rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Chain wiring: one entry per cell
  logic [DATA_W-1:0]     cell_data [CAPACITY];
  logic [PRIO_WIDTH-1:0] cell_prio [CAPACITY];
  logic [CAPACITY-1:0]   cell_after;
  logic [CAPACITY-1:0]   occupied;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  logic                  accept;
  logic                  is_insert;
  logic                  is_full;
  logic                  is_empty;
  logic [31:0]           prio_ext;
  logic [PRIO_WIDTH-1:0] new_prio;
  cell_ctl_t             ctl;

  logic                  res_valid;
  logic [DATA_W-1:0]     res_data;
  status_t               res_status;
  logic [OCC_W-1:0]      res_occ;
  logic [DATA_W-1:0]     res_data_next;
  status_t               res_status_next;
  logic [31:0]           count_ext;

  // Take a request whenever the output register is free or being drained;
  // hold off while in reset so no transaction is taken and then dropped
  assign req.ready = !rst && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign is_insert = (req.cmd == CMD_INSERT);
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign is_empty  = (count == '0);

  // Use only the low PRIO_WIDTH bits of the request's priority
  assign prio_ext = {16'b0, req.prio_in};
  assign new_prio = prio_ext[PRIO_WIDTH-1:0];

  // Broadcast the operation to every cell; drop full inserts and empty removes
  always_comb begin
    ctl.data = req.data_in;
    ctl.op   = OP_HOLD;
    if (accept) begin
      if (is_insert && !is_full) begin
        ctl.op = OP_INSERT;
      end else if (!is_insert && !is_empty) begin
        ctl.op = OP_REMOVE;
      end
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                  l_after;
      logic [DATA_W-1:0]     l_data;
      logic [PRIO_WIDTH-1:0] l_prio;
      logic [DATA_W-1:0]     r_data;
      logic [PRIO_WIDTH-1:0] r_prio;

      // Slots below the count are live
      assign occupied[gi] = (CNT_W'(gi) < count);

      if (gi == 0) begin : g_head
        assign l_after = 1'b1;
        assign l_data  = cell_data[gi];
        assign l_prio  = cell_prio[gi];
      end else begin : g_body
        assign l_after = cell_after[gi-1];
        assign l_data  = cell_data[gi-1];
        assign l_prio  = cell_prio[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign r_data = cell_data[gi];
        assign r_prio = cell_prio[gi];
      end else begin : g_inner
        assign r_data = cell_data[gi+1];
        assign r_prio = cell_prio[gi+1];
      end

      sspq_cell #(
        .PRIO_WIDTH (PRIO_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_prio   (new_prio),
        .occupied   (occupied[gi]),
        .left_after (l_after),
        .left_data  (l_data),
        .left_prio  (l_prio),
        .right_data (r_data),
        .right_prio (r_prio),
        .data       (cell_data[gi]),
        .prio       (cell_prio[gi]),
        .after      (cell_after[gi])
      );
    end
  endgenerate

  // Count follows the operation actually applied to the chain
  always_comb begin
    case (ctl.op)
      OP_INSERT: count_next = count + CNT_W'(1);
      OP_REMOVE: count_next = count - CNT_W'(1);
      default:   count_next = count;
    endcase
  end

  // Build the response from the state before the update
  always_comb begin
    res_data_next   = '0;
    res_status_next = ST_OK;
    if (is_insert) begin
      if (is_full) begin
        res_status_next = ST_FULL;
      end
    end else if (is_empty) begin
      res_status_next = ST_EMPTY;
    end else begin
      res_data_next = cell_data[0];
    end
  end

  assign count_ext = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Hold the response payload until the next accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data   <= res_data_next;
      res_status <= res_status_next;
      res_occ    <= count_ext[OCC_W-1:0];
    end
  end

  assign rsp.valid     = res_valid;
  assign rsp.data_out  = res_data;
  assign rsp.status    = res_status;
  assign rsp.occupancy = res_occ;

  // Count never runs past the chain length
  `SSPQ_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count exceeds capacity")

  // A full insert reports full and leaves the count alone
  `SSPQ_ASSERT(a_full_drop, (accept && is_insert && is_full) |=> (rsp.valid && rsp.status == ST_FULL && count == $past(count)), "full insert not dropped")

  // A remove from a non-empty queue shrinks the count by one
  `SSPQ_ASSERT(a_remove_count, (accept && !is_insert && !is_empty) |=> (count == $past(count) - CNT_W'(1)), "remove did not shrink count")

  // A remove from an empty queue returns a zero handle with empty status
  `SSPQ_ASSERT(a_empty_remove, (accept && !is_insert && is_empty) |=> (rsp.status == ST_EMPTY && rsp.data_out == '0), "empty remove misreported")

endmodule

FILE: src/sspq_cell.sv
// One slot of the sorted chain: holds a handle and its priority.
// Depends on sspq_pkg; neighbors are wired by the top level.
module sspq_cell import sspq_pkg::*; #(
  parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [PRIO_WIDTH-1:0] new_prio,
  input  logic                  occupied,
  input  logic                  left_after,
  input  logic [DATA_W-1:0]     left_data,
  input  logic [PRIO_WIDTH-1:0] left_prio,
  input  logic [DATA_W-1:0]     right_data,
  input  logic [PRIO_WIDTH-1:0] right_prio,
  output logic [DATA_W-1:0]     data,
  output logic [PRIO_WIDTH-1:0] prio,
  output logic                  after
);

  logic [DATA_W-1:0]     data_next;
  logic [PRIO_WIDTH-1:0] prio_next;

  // New entry goes behind this slot when it holds an equal or lower priority
  assign after = occupied && (prio <= new_prio);

  always_comb begin
    data_next = data;
    prio_next = prio;
    case (ctl.op)
      OP_INSERT: begin
        if (after) begin
          data_next = data;
          prio_next = prio;
        end else if (left_after) begin
          data_next = ctl.data;
          prio_next = new_prio;
        end else begin
          data_next = left_data;
          prio_next = left_prio;
        end
      end
      OP_REMOVE: begin
        data_next = right_data;
        prio_next = right_prio;
      end
      default: begin
        data_next = data;
        prio_next = prio;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule
